/* rtl/core/kda_pkg.sv */
package kda_pkg;

    localparam int unsigned EVT_CNT_W = 7;
    localparam int unsigned CFG_AW    = 5;

    localparam logic [7:0] DEBOUNCE_RST  = 8'd3;
    localparam logic [7:0] HOLD_RST      = 8'd100;
    localparam logic [7:0] REPEATS1_RST  = 8'd10;
    localparam logic [7:0] REPEATS2_RST  = 8'd10;
    localparam logic [7:0] REPEATS3_RST  = 8'd10;
    localparam logic [7:0] PERIOD1_RST   = 8'd20;
    localparam logic [7:0] PERIOD2_RST   = 8'd10;
    localparam logic [7:0] PERIOD3_RST   = 8'd5;

    localparam logic [EVT_CNT_W-1:0] EVT_SINGLE = EVT_CNT_W'(1);
    localparam logic [EVT_CNT_W-1:0] EVT_TRIPLE = EVT_CNT_W'(3);

    localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [2:0] REG_HOLD      = 3'd1;
    localparam logic [2:0] REG_REPEATS1  = 3'd2;
    localparam logic [2:0] REG_REPEATS2  = 3'd3;
    localparam logic [2:0] REG_REPEATS3  = 3'd4;
    localparam logic [2:0] REG_PERIOD1   = 3'd5;
    localparam logic [2:0] REG_PERIOD2   = 3'd6;
    localparam logic [2:0] REG_PERIOD3   = 3'd7;

    typedef enum logic [2:0] {
        SPD_IDLE  = 3'd0,
        SPD_ONE   = 3'd1,
        SPD_TWO   = 3'd2,
        SPD_THREE = 3'd3,
        SPD_BURST = 3'd4
    } speed_t;

    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [7:0] hold_before_repeat;
        logic [7:0] repeats_speed_one;
        logic [7:0] repeats_speed_two;
        logic [7:0] repeats_speed_three;
        logic [7:0] period_speed_one;
        logic [7:0] period_speed_two;
        logic [7:0] period_speed_three;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           key_id;
        logic [EVT_CNT_W-1:0] count;
    } cmd_t;

    function automatic logic [7:0] period_of(cfg_t c, speed_t s);
        logic [7:0] p;
        p = c.period_speed_one;
        case (s)
            SPD_TWO:   p = c.period_speed_two;
            SPD_THREE: p = c.period_speed_three;
            default:   p = c.period_speed_one;
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/kda_front.sv */
module kda_front import kda_pkg::*; #(
    parameter int unsigned BURST_COUNT = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       push,
    input  logic [3:0] keys_pressed,
    output logic       full,
    input  logic       cmd_full,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic       accept;
    logic       press_latched_reg, press_latched_next;
    logic [7:0] debounce_left_reg, debounce_left_next;
    logic [7:0] hold_left_reg, hold_left_next;
    logic       repeat_active_reg, repeat_active_next;
    speed_t     speed_reg, speed_next;
    logic [7:0] repeat_timer_reg, repeat_timer_next;
    logic [3:0] pattern_reg, pattern_next;
    logic [EVT_CNT_W-1:0] evt_cnt;
    logic       single;
    logic [1:0] key_id;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    always_comb
    begin
        press_latched_next = press_latched_reg;
        debounce_left_next = debounce_left_reg;
        hold_left_next     = hold_left_reg;
        repeat_active_next = repeat_active_reg;
        speed_next         = speed_reg;
        repeat_timer_next  = repeat_timer_reg;
        pattern_next       = pattern_reg;
        evt_cnt            = '0;

        if (keys_pressed != 4'd0)
        begin
            if (press_latched_reg)
            begin
                if (!repeat_active_reg)
                begin
                    hold_left_next = hold_left_reg - 8'd1;
                    if (hold_left_next == 8'd0)
                    begin
                        hold_left_next     = cfg.repeats_speed_one;
                        repeat_active_next = 1'b1;
                        speed_next         = SPD_ONE;
                        repeat_timer_next  = cfg.period_speed_one;
                    end
                end
            end
            else
            begin
                debounce_left_next = debounce_left_reg - 8'd1;
                if (debounce_left_next == 8'd0)
                begin
                    press_latched_next = 1'b1;
                    pattern_next       = keys_pressed;
                    evt_cnt            = EVT_SINGLE;
                end
            end
        end
        else
        begin
            repeat_active_next = 1'b0;
            speed_next         = SPD_IDLE;
            press_latched_next = 1'b0;
            debounce_left_next = cfg.debounce_ticks;
            hold_left_next     = cfg.hold_before_repeat;
        end

        if (repeat_active_next)
        begin
            case (speed_next) inside
                SPD_ONE, SPD_TWO, SPD_THREE:
                begin
                    repeat_timer_next = repeat_timer_next - 8'd1;
                    if (repeat_timer_next == 8'd0)
                    begin
                        repeat_timer_next = period_of(cfg, speed_next);
                        evt_cnt = (speed_next == SPD_THREE) ? EVT_TRIPLE : EVT_SINGLE;
                        hold_left_next = hold_left_next - 8'd1;
                        if (hold_left_next == 8'd0)
                        begin
                            case (speed_next)
                                SPD_ONE:
                                begin
                                    hold_left_next = cfg.repeats_speed_two;
                                    speed_next     = SPD_TWO;
                                end
                                SPD_TWO:
                                begin
                                    hold_left_next = cfg.repeats_speed_three;
                                    speed_next     = SPD_THREE;
                                end
                                default:
                                begin
                                    speed_next = SPD_BURST;
                                end
                            endcase
                            if (speed_next != SPD_BURST)
                            begin
                                repeat_timer_next = period_of(cfg, speed_next);
                            end
                        end
                    end
                end
                SPD_BURST:
                begin
                    evt_cnt           = EVT_CNT_W'(BURST_COUNT);
                    repeat_timer_next = 8'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // only single-key patterns produce events
    always_comb
    begin
        single = 1'b1;
        key_id = 2'd0;
        unique case (pattern_next)
            4'b0001: key_id = 2'd0;
            4'b0010: key_id = 2'd1;
            4'b0100: key_id = 2'd2;
            4'b1000: key_id = 2'd3;
            default: single = 1'b0;
        endcase
    end

    assign cmd_push   = accept && single && (evt_cnt != '0);
    assign cmd.key_id = key_id;
    assign cmd.count  = evt_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_latched_reg <= 1'b0;
            debounce_left_reg <= DEBOUNCE_RST;
            hold_left_reg     <= HOLD_RST;
            repeat_active_reg <= 1'b0;
            speed_reg         <= SPD_IDLE;
            pattern_reg       <= 4'd0;
        end
        else if (accept)
        begin
            press_latched_reg <= press_latched_next;
            debounce_left_reg <= debounce_left_next;
            hold_left_reg     <= hold_left_next;
            repeat_active_reg <= repeat_active_next;
            speed_reg         <= speed_next;
            pattern_reg       <= pattern_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            repeat_timer_reg <= repeat_timer_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        repeat_active_reg |-> press_latched_reg)
        else $error("auto-repeat without latched press");

    assert property (@(posedge clk) disable iff (!rst_n)
        (speed_reg != SPD_IDLE) == repeat_active_reg)
        else $error("speed level out of step with auto-repeat");

endmodule

/* rtl/core/kda_cmd_fifo.sv */
module kda_cmd_fifo import kda_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr;
    logic       do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("command queue overflow");

endmodule

/* rtl/core/kda_back.sv */
module kda_back import kda_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_empty,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] key_id,
    output logic       last
);

    cmd_t cur_reg;
    logic cur_valid_reg;
    logic transfer;
    logic done;

    assign transfer = pop && cur_valid_reg;
    assign done     = transfer && (cur_reg.count == EVT_SINGLE);
    assign cmd_pop  = !cmd_empty && (!cur_valid_reg || done);

    assign empty  = !cur_valid_reg;
    assign key_id = cur_reg.key_id;
    assign last   = (cur_reg.count == EVT_SINGLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (cmd_pop)
        begin
            cur_valid_reg <= 1'b1;
        end
        else if (done)
        begin
            cur_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        else if (transfer)
        begin
            cur_reg.count <= cur_reg.count - EVT_SINGLE;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.count != '0))
        else $error("active burst with zero events left");

endmodule

/* rtl/core/key_debounce_autorepeat.sv */
// An accepted tick gives 1, 3 or BURST_COUNT events; the first enters the command queue,
// then the output register, then the result ports. Throughput: one tick per cycle while
// the queue is not full; results leave at one event per cycle while pop is held.
// A 2-entry command queue between tick processing and event output sets the slack.
// Reset (rst_n low, async): configuration and counters but repeat_timer reset to defaults.
module key_debounce_autorepeat import kda_pkg::*; #(
    parameter int unsigned BURST_COUNT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  logic [3:0]        keys_pressed,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        key_id,
    output logic              last
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic [7:0] rd_val;
    logic       cmd_push;
    logic       cmd_full;
    logic       cmd_pop;
    logic       cmd_empty;
    cmd_t       cmd_in;
    cmd_t       cmd_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign prdata  = {24'd0, rd_val};

    always_comb
    begin
        unique case (reg_idx)
            REG_DEBOUNCE: rd_val = cfg_reg.debounce_ticks;
            REG_HOLD:     rd_val = cfg_reg.hold_before_repeat;
            REG_REPEATS1: rd_val = cfg_reg.repeats_speed_one;
            REG_REPEATS2: rd_val = cfg_reg.repeats_speed_two;
            REG_REPEATS3: rd_val = cfg_reg.repeats_speed_three;
            REG_PERIOD1:  rd_val = cfg_reg.period_speed_one;
            REG_PERIOD2:  rd_val = cfg_reg.period_speed_two;
            REG_PERIOD3:  rd_val = cfg_reg.period_speed_three;
            default:      rd_val = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks      <= DEBOUNCE_RST;
            cfg_reg.hold_before_repeat  <= HOLD_RST;
            cfg_reg.repeats_speed_one   <= REPEATS1_RST;
            cfg_reg.repeats_speed_two   <= REPEATS2_RST;
            cfg_reg.repeats_speed_three <= REPEATS3_RST;
            cfg_reg.period_speed_one    <= PERIOD1_RST;
            cfg_reg.period_speed_two    <= PERIOD2_RST;
            cfg_reg.period_speed_three  <= PERIOD3_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_DEBOUNCE: cfg_reg.debounce_ticks      <= pwdata[7:0];
                REG_HOLD:     cfg_reg.hold_before_repeat  <= pwdata[7:0];
                REG_REPEATS1: cfg_reg.repeats_speed_one   <= pwdata[7:0];
                REG_REPEATS2: cfg_reg.repeats_speed_two   <= pwdata[7:0];
                REG_REPEATS3: cfg_reg.repeats_speed_three <= pwdata[7:0];
                REG_PERIOD1:  cfg_reg.period_speed_one    <= pwdata[7:0];
                REG_PERIOD2:  cfg_reg.period_speed_two    <= pwdata[7:0];
                REG_PERIOD3:  cfg_reg.period_speed_three  <= pwdata[7:0];
                default:      cfg_reg.debounce_ticks      <= cfg_reg.debounce_ticks;
            endcase
        end
    end

    kda_front #(
        .BURST_COUNT (BURST_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .keys_pressed (keys_pressed),
        .full         (full),
        .cmd_full     (cmd_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    kda_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    kda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .key_id    (key_id),
        .last      (last)
    );

endmodule
